### hw/rtl/jsu_pkg.sv
// Shared types, constants and the UTF-8 encoder for the JSON string unescape unit.
// No dependencies; every other file in hw/rtl imports this package.

package jsu_pkg;

  // Width of the running decoded-length counter (8..32); the reported length saturates at 16 bits
  localparam int LENGTH_WIDTH = 16;
  localparam int OUT_LEN_W    = 16;

  // Entry queue between front and back; depth must be a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Surrogate ranges and supplementary-plane base
  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_WANT_BS = 3'd3,
    MODE_WANT_U  = 3'd4,
    MODE_HEX_LO  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_BYTES = 2'd1,
    ACT_END   = 2'd2,
    ACT_ERR   = 2'd3
  } act_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [1:0]           kind;
    logic [OUT_LEN_W-1:0] decoded_length;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [1:0]      nm1;    // byte count minus one
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
  } utf8_t;

  // One queued transaction group: up to four bytes, or an end / error marker
  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           nm1;
    logic [3:0][7:0]      bytes;
    logic [OUT_LEN_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.nm1      = 2'd0;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.nm1      = 2'd1;
      r.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.nm1      = 2'd2;
      r.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
    end else begin
      r.nm1      = 2'd3;
      r.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
    end
    return r;
  endfunction

endpackage

### hw/rtl/jsu_front.sv
// Front end: accepts raw string bytes, runs the escape decoder and pushes result groups.
// Depends on jsu_pkg.

module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  jsu_pkg::in_t     in_data,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             push,
  output jsu_pkg::entry_t  push_entry
);
  import jsu_pkg::*;

  mode_t                   mode, mode_next;
  logic [1:0]              hex_cnt, hex_cnt_next;
  logic [15:0]             code_accum, code_accum_next;
  logic [9:0]              high_surr, high_surr_next;
  logic [LENGTH_WIDTH-1:0] length_count, length_count_next;

  logic                    accept;
  logic [7:0]              c;
  logic                    hex_ok;
  logic [3:0]              hex_v;
  logic [15:0]             acc_shift;
  logic [20:0]             full_cp;
  utf8_t                   enc;
  logic                    is_hi, is_lo;
  act_t                    act;
  logic                    use_enc;
  logic [7:0]              sbyte;
  logic [1:0]              nm1;
  logic [LENGTH_WIDTH:0]   len_sum;
  logic [LENGTH_WIDTH+OUT_LEN_W-1:0] len_wide;
  logic [OUT_LEN_W-1:0]    len_sat;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.in_byte;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (c >= "0" && c <= "9") begin
      hex_v = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      hex_v = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      hex_v = 4'(c - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_shift = {code_accum[11:0], hex_v};
  assign is_hi     = (acc_shift >= SURR_HI_MIN) && (acc_shift <= SURR_HI_MAX);
  assign is_lo     = (acc_shift >= SURR_LO_MIN) && (acc_shift <= SURR_LO_MAX);
  assign full_cp   = (mode == MODE_HEX_LO) ? SUPP_BASE + {1'b0, high_surr, acc_shift[9:0]}
                                           : {5'b0, acc_shift};
  assign enc       = utf8_encode(full_cp);

  // Classify the incoming byte
  always_comb begin
    act     = ACT_NONE;
    use_enc = 1'b0;
    sbyte   = c;
    if (in_data.end_of_input) begin
      act = ACT_ERR;
    end else begin
      unique case (mode)
        MODE_ESC: begin
          priority case (c)
            "\"", "\\", "/": act = ACT_BYTES;
            "b": begin act = ACT_BYTES; sbyte = 8'h08; end
            "f": begin act = ACT_BYTES; sbyte = 8'h0C; end
            "n": begin act = ACT_BYTES; sbyte = 8'h0A; end
            "r": begin act = ACT_BYTES; sbyte = 8'h0D; end
            "t": begin act = ACT_BYTES; sbyte = 8'h09; end
            "u": act = ACT_NONE;
            default: act = ACT_ERR;
          endcase
        end
        MODE_HEX, MODE_HEX_LO: begin
          if (!hex_ok) begin
            act = ACT_ERR;
          end else if (hex_cnt != 2'd3) begin
            act = ACT_NONE;
          end else if (mode == MODE_HEX_LO) begin
            act     = is_lo ? ACT_BYTES : ACT_ERR;
            use_enc = 1'b1;
          end else if (is_hi) begin
            act = ACT_NONE;
          end else if (is_lo) begin
            act = ACT_ERR;
          end else begin
            act     = ACT_BYTES;
            use_enc = 1'b1;
          end
        end
        MODE_WANT_BS: act = (c == "\\") ? ACT_NONE : ACT_ERR;
        MODE_WANT_U:  act = (c == "u") ? ACT_NONE : ACT_ERR;
        default: begin
          if (c == "\"") begin
            act = ACT_END;
          end else if (c == "\\") begin
            act = ACT_NONE;
          end else begin
            act = ACT_BYTES;
          end
        end
      endcase
    end
  end

  assign nm1     = use_enc ? enc.nm1 : 2'd0;
  assign len_sum = {1'b0, length_count} + (LENGTH_WIDTH+1)'(nm1) + (LENGTH_WIDTH+1)'(1);

  // Next state
  always_comb begin
    mode_next         = mode;
    hex_cnt_next      = hex_cnt;
    code_accum_next   = code_accum;
    high_surr_next    = high_surr;
    length_count_next = length_count;
    if (accept) begin
      if (act == ACT_ERR || act == ACT_END) begin
        mode_next         = MODE_PLAIN;
        hex_cnt_next      = 2'd0;
        code_accum_next   = 16'd0;
        high_surr_next    = 10'd0;
        length_count_next = '0;
      end else begin
        if (act == ACT_BYTES) begin
          length_count_next = len_sum[LENGTH_WIDTH] ? '1 : len_sum[LENGTH_WIDTH-1:0];
        end
        unique case (mode)
          MODE_ESC: begin
            if (c == "u") begin
              mode_next       = MODE_HEX;
              hex_cnt_next    = 2'd0;
              code_accum_next = 16'd0;
            end else begin
              mode_next = MODE_PLAIN;
            end
          end
          MODE_HEX, MODE_HEX_LO: begin
            if (hex_cnt != 2'd3) begin
              hex_cnt_next    = hex_cnt + 2'd1;
              code_accum_next = acc_shift;
            end else begin
              hex_cnt_next    = 2'd0;
              code_accum_next = 16'd0;
              if (mode == MODE_HEX_LO) begin
                mode_next      = MODE_PLAIN;
                high_surr_next = 10'd0;
              end else if (is_hi) begin
                mode_next      = MODE_WANT_BS;
                high_surr_next = acc_shift[9:0];
              end else begin
                mode_next = MODE_PLAIN;
              end
            end
          end
          MODE_WANT_BS: mode_next = MODE_WANT_U;
          MODE_WANT_U: begin
            mode_next       = MODE_HEX_LO;
            hex_cnt_next    = 2'd0;
            code_accum_next = 16'd0;
          end
          default: begin
            if (c == "\\") begin
              mode_next = MODE_ESC;
            end else begin
              mode_next = MODE_PLAIN;
            end
          end
        endcase
      end
    end
  end

  assign len_wide = (LENGTH_WIDTH+OUT_LEN_W)'(length_count);
  assign len_sat  = (len_wide > (LENGTH_WIDTH+OUT_LEN_W)'({OUT_LEN_W{1'b1}}))
                    ? '1 : len_wide[OUT_LEN_W-1:0];

  // Outputs toward the queue
  always_comb begin
    push             = accept && (act != ACT_NONE);
    push_entry.nm1   = nm1;
    push_entry.bytes = '0;
    push_entry.length = '0;
    unique case (act)
      ACT_END: begin
        push_entry.kind   = KIND_END;
        push_entry.length = len_sat;
      end
      ACT_ERR: push_entry.kind = KIND_ERR;
      default: begin
        push_entry.kind  = KIND_BYTE;
        push_entry.bytes = use_enc ? enc.bytes : {24'b0, sbyte};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PLAIN;
      hex_cnt      <= 2'd0;
      code_accum   <= 16'd0;
      high_surr    <= 10'd0;
      length_count <= '0;
    end else begin
      mode         <= mode_next;
      hex_cnt      <= hex_cnt_next;
      code_accum   <= code_accum_next;
      high_surr    <= high_surr_next;
      length_count <= length_count_next;
    end
  end

endmodule

### hw/rtl/jsu_fifo.sv
// Small entry queue that decouples the decoder front end from the byte emitter.
// Depends on jsu_pkg.

module jsu_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::entry_t  push_entry,
  input  logic             pop,
  output jsu_pkg::entry_t  head,
  output jsu_pkg::q_stat_t q_stat
);
  import jsu_pkg::*;

  entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

### hw/rtl/jsu_back.sv
// Back end: walks the queued entries one byte per cycle into a registered output,
// stalling while out_ready is low. Depends on jsu_pkg.

module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::q_stat_t q_stat,
  input  jsu_pkg::entry_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output jsu_pkg::out_t    out_data
);
  import jsu_pkg::*;

  logic [1:0] idx, idx_next;
  logic       out_valid_next;
  logic       advance;
  logic       head_last;
  out_t       res;

  assign advance   = !out_valid || out_ready;
  assign head_last = (head.kind != KIND_BYTE) || (idx == head.nm1);
  assign pop       = advance && !q_stat.empty && head_last;

  always_comb begin
    res.out_byte       = head.bytes[idx];
    res.kind           = head.kind;
    res.decoded_length = head.length;
    res.last           = head_last;
  end

  always_comb begin
    idx_next       = idx;
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = !q_stat.empty;
      if (!q_stat.empty) begin
        idx_next = head_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_stat.empty) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/json_string_unescape_utf8_unit.sv
// JSON string body decoder: takes one raw byte per transaction (opening quote already consumed)
// and returns decoded bytes, an end marker with the decoded length, or a parse error. A \uXXXX
// escape expands to one to three UTF-8 bytes, or four for a surrogate pair; a high surrogate
// must be followed by a \u low surrogate. An input byte is accepted every cycle while the
// four-entry queue between the decoder and the emitter has room; the emitter sends one result
// per cycle while out_ready is high, so the bytes of an escape go out one at a time. The
// decoded length saturates at 65535. Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.

module json_string_unescape_utf8_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jsu_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jsu_pkg::out_t  out_data
);
  import jsu_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  entry_t  push_entry;
  entry_t  head;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (push_entry)
  );

  jsu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != KIND_BYTE) |-> out_data.last)
    else $error("end or error transaction not marked last");

  a_len_only_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != KIND_END) |-> (out_data.decoded_length == '0))
    else $error("nonzero length on byte or error transaction");
`endif

endmodule
